[hdl/pfst_pkg.sv]
// ----------------------------------------------------------------------------
// pfst_pkg: shared types and codes of the Pauli frame sign tracker.
// Holds the term layout, the result status codes, the function codes and the
// command and status groups that link the controller to the datapath.
// ----------------------------------------------------------------------------
package pfst_pkg;

  localparam int QubitW = 64;
  localparam int CondW  = 7;
  localparam int StatW  = 2;

  // Function codes of an input item.
  localparam logic FuncAdd   = 1'b0;
  localparam logic FuncQuery = 1'b1;

  // Result status codes.
  localparam logic [StatW-1:0] StatusOk      = 2'd0;
  localparam logic [StatW-1:0] StatusFull    = 2'd1;
  localparam logic [StatW-1:0] StatusBadCond = 2'd2;

  // Configuration register indexes.
  localparam logic RegQubitCount = 1'b0;

  // One stored term.
  typedef struct packed {
    logic [QubitW-1:0] x;
    logic [QubitW-1:0] z;
    logic [CondW-1:0]  cond;
  } term_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the accepted item and clear the scan state
    logic add_exec;    // decide the add status, store the term, emit result
    logic scan_step;   // read the next term and advance the scan index
    logic walk_step;   // shift the sign set by one id, emit if the bit is set
    logic emit_empty;  // emit the single empty-set result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;    // every stored term has been read
    logic rd_pend;     // a read is still on its way into the sign set
    logic set_zero;    // the sign set is empty
    logic bit0;        // the lowest remaining id is in the set
    logic last_bit;    // the lowest remaining id is the final one
    logic out_free;    // the result register can take a new result
  } sts_t;

endpackage

[hdl/pfst_datapath.sv]
// ----------------------------------------------------------------------------
// pfst_datapath: term memory, sign set accumulator and result register.
// Executes the controller's commands one step per cycle and reports the
// scan, sign set and output conditions back to it.
// ----------------------------------------------------------------------------
module pfst_datapath #(
  parameter int MAX_TERMS = 256,
  parameter int COND_IDS  = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pfst_pkg::cmd_t                cmd,
  output pfst_pkg::sts_t                sts,
  input  logic [pfst_pkg::CondW-1:0]    qubit_count,
  input  logic [pfst_pkg::QubitW-1:0]   in_x_mask,
  input  logic [pfst_pkg::QubitW-1:0]   in_z_mask,
  input  logic [pfst_pkg::CondW-1:0]    in_condition_id,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [pfst_pkg::StatW-1:0]    out_status,
  output logic [pfst_pkg::CondW-1:0]    out_cond_out,
  output logic                          out_empty_set,
  output logic                          out_last
);

  localparam int AddrW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CntW  = $clog2(MAX_TERMS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_TERMS);
  localparam logic [pfst_pkg::CondW-1:0] CondMax = pfst_pkg::CondW'(COND_IDS);

  pfst_pkg::term_t mem [MAX_TERMS];

  logic [pfst_pkg::QubitW-1:0] qx_r, qz_r;
  logic [pfst_pkg::CondW-1:0]  cid_r;
  logic [pfst_pkg::QubitW-1:0] qmask;
  logic [CntW-1:0]             term_count_r, scan_idx_r;
  logic                        rd_valid_r;
  pfst_pkg::term_t             rd_q;
  logic [COND_IDS-1:0]         set_r, set_nxt, set_rest;
  logic [pfst_pkg::CondW-1:0]  walk_id_r;
  logic                        parity;
  logic                        bad_cond, full, add_ok;
  logic                        out_free;

  // Mask of the qubits in use; counts of 64 and above keep every bit.
  always_comb begin
    if (qubit_count >= pfst_pkg::CondW'(pfst_pkg::QubitW)) begin
      qmask = '1;
    end else begin
      qmask = (pfst_pkg::QubitW'(1) << qubit_count[5:0]) - pfst_pkg::QubitW'(1);
    end
  end

  assign bad_cond = (cid_r == '0) || (cid_r > CondMax);
  assign full     = (term_count_r == CntMax);
  assign add_ok   = cmd.add_exec && !bad_cond && !full;
  assign out_free = !out_valid || out_ready;

  assign parity = (^(qx_r & rd_q.z)) ^ (^(qz_r & rd_q.x));

  // Each odd term toggles the bit of its condition id.
  always_comb begin
    set_nxt = set_r;
    for (int j = 0; j < COND_IDS; j++) begin
      if (rd_valid_r && parity && (rd_q.cond == pfst_pkg::CondW'(j + 1))) begin
        set_nxt[j] = ~set_r[j];
      end
    end
  end

  assign set_rest = set_r >> 1;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      qx_r  <= in_x_mask & qmask;
      qz_r  <= in_z_mask & qmask;
      cid_r <= in_condition_id;
    end
  end

  always_ff @(posedge clk) begin
    if (add_ok) begin
      mem[term_count_r[AddrW-1:0]] <= '{x: qx_r, z: qz_r, cond: cid_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      rd_q <= mem[scan_idx_r[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= '0;
      scan_idx_r   <= '0;
      rd_valid_r   <= 1'b0;
      set_r        <= '0;
      walk_id_r    <= '0;
    end else begin
      rd_valid_r <= cmd.scan_step;
      if (add_ok) begin
        term_count_r <= term_count_r + CntW'(1);
      end
      if (cmd.capture) begin
        scan_idx_r <= '0;
        set_r      <= '0;
        walk_id_r  <= pfst_pkg::CondW'(1);
      end else if (cmd.walk_step) begin
        set_r     <= set_rest;
        walk_id_r <= walk_id_r + pfst_pkg::CondW'(1);
      end else begin
        set_r <= set_nxt;
        if (cmd.scan_step) begin
          scan_idx_r <= scan_idx_r + CntW'(1);
        end
      end
    end
  end

  // Result register: loaded on an emit, cleared once the result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.add_exec || cmd.emit_empty || (cmd.walk_step && set_r[0])) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_exec) begin
      if (bad_cond) begin
        out_status <= pfst_pkg::StatusBadCond;
      end else if (full) begin
        out_status <= pfst_pkg::StatusFull;
      end else begin
        out_status <= pfst_pkg::StatusOk;
      end
      out_cond_out  <= '0;
      out_empty_set <= 1'b0;
      out_last      <= 1'b1;
    end else if (cmd.emit_empty) begin
      out_status    <= pfst_pkg::StatusOk;
      out_cond_out  <= '0;
      out_empty_set <= 1'b1;
      out_last      <= 1'b1;
    end else if (cmd.walk_step && set_r[0]) begin
      out_status    <= pfst_pkg::StatusOk;
      out_cond_out  <= walk_id_r;
      out_empty_set <= 1'b0;
      out_last      <= (set_rest == '0);
    end
  end

  assign sts.scan_end = (scan_idx_r == term_count_r);
  assign sts.rd_pend  = rd_valid_r;
  assign sts.set_zero = (set_r == '0);
  assign sts.bit0     = set_r[0];
  assign sts.last_bit = (set_rest == '0);
  assign sts.out_free = out_free;

endmodule

[hdl/pfst_ctrl.sv]
// ----------------------------------------------------------------------------
// pfst_ctrl: sequencing state machine of the sign tracker.
// Takes one item at a time and steps the datapath through the add, the
// term scan and the walk over the sign set.
// ----------------------------------------------------------------------------
module pfst_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_func,
  output logic           in_ready,
  output pfst_pkg::cmd_t cmd,
  input  pfst_pkg::sts_t sts
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StAdd   = 3'd1;
  localparam logic [2:0] StScan  = 3'd2;
  localparam logic [2:0] StEmpty = 3'd3;
  localparam logic [2:0] StWalk  = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == StIdle);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      StIdle: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_func == pfst_pkg::FuncQuery) ? StScan : StAdd;
        end
      end
      StAdd: begin
        if (sts.out_free) begin
          cmd.add_exec = 1'b1;
          state_nxt    = StIdle;
        end
      end
      StScan: begin
        if (!sts.scan_end) begin
          cmd.scan_step = 1'b1;
        end else if (!sts.rd_pend) begin
          state_nxt = sts.set_zero ? StEmpty : StWalk;
        end
      end
      StEmpty: begin
        if (sts.out_free) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = StIdle;
        end
      end
      StWalk: begin
        if (!sts.bit0) begin
          cmd.walk_step = 1'b1;
        end else if (sts.out_free) begin
          cmd.walk_step = 1'b1;
          if (sts.last_bit) begin
            state_nxt = StIdle;
          end
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/pauli_frame_sign_tracker_core.sv]
// The block takes one item at a time: an add is decided before the next item is taken,
// and a query first reads every stored term through the single read port of the term
// memory, then walks the sign set one id per cycle, holding on a member while the
// result register is busy. Reset (synchronous, rst_n low) empties the table and sets
// qubit_count to 64; the term memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// pauli_frame_sign_tracker_core: Pauli term table with sign condition queries.
// Stores Pauli terms with a condition id and, for a query Pauli, lists the
// condition ids whose anticommuting terms occur an odd number of times.
// ----------------------------------------------------------------------------
module pauli_frame_sign_tracker_core #(
  parameter int MAX_TERMS = 256,
  parameter int COND_IDS  = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input item channel.
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_func,
  input  logic [pfst_pkg::QubitW-1:0] in_x_mask,
  input  logic [pfst_pkg::QubitW-1:0] in_z_mask,
  input  logic [pfst_pkg::CondW-1:0]  in_condition_id,
  // Result item channel.
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pfst_pkg::StatW-1:0]  out_status,
  output logic [pfst_pkg::CondW-1:0]  out_cond_out,
  output logic                        out_empty_set,
  output logic                        out_last,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  // The controller and the datapath talk only through these two groups.
  pfst_pkg::cmd_t cmd;
  pfst_pkg::sts_t sts;

  logic [pfst_pkg::CondW-1:0] qubit_count_r;
  logic                       cfg_hit;

  // The port never stalls. The only register, qubit_count, sits at byte
  // address 0; the upper address bit selects the register index, and a
  // write to any other index is ignored.
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == pfst_pkg::RegQubitCount);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qubit_count_r <= pfst_pkg::CondW'(pfst_pkg::QubitW);
    end else if (psel && penable && pwrite && cfg_hit) begin
      qubit_count_r <= pwdata[pfst_pkg::CondW-1:0];
    end
  end

  // Reads return the register value; unused indexes read as zero.
  always_comb begin
    if (cfg_hit) begin
      prdata = {{(32 - pfst_pkg::CondW){1'b0}}, qubit_count_r};
    end else begin
      prdata = '0;
    end
  end

  // The controller takes one item at a time. An add is decided in the
  // StAdd state that follows its capture, as soon as the result register is free. A
  // query reads the stored terms one per cycle, folds their parities into
  // the sign set, and then walks the set from the lowest id upward,
  // emitting each member as the result register frees up.
  pfst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // The datapath masks the item with the qubit mask as it is captured, so
  // stored terms and the query both lose their bits from index qubit_count up.
  pfst_datapath #(
    .MAX_TERMS (MAX_TERMS),
    .COND_IDS  (COND_IDS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .qubit_count     (qubit_count_r),
    .in_x_mask       (in_x_mask),
    .in_z_mask       (in_z_mask),
    .in_condition_id (in_condition_id),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_cond_out    (out_cond_out),
    .out_empty_set   (out_empty_set),
    .out_last        (out_last)
  );

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Pauli frame sign tracker core testbench.
// A queue of add and query items feeds a driver that presents them with
// random gaps, while a monitor accepts results under random back-pressure
// and compares each one with the prediction of a local model of the term
// table. The qubit count register is rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxTerms   = 256;
  localparam int CondIds    = 64;
  localparam int CycleLimit = 1500000;

  localparam int QubitW = pfst_pkg::QubitW;
  localparam int CondW  = pfst_pkg::CondW;
  localparam int StatW  = pfst_pkg::StatW;

  localparam logic             FuncAdd       = pfst_pkg::FuncAdd;
  localparam logic             FuncQuery     = pfst_pkg::FuncQuery;
  localparam logic [StatW-1:0] StatusOk      = pfst_pkg::StatusOk;
  localparam logic [StatW-1:0] StatusFull    = pfst_pkg::StatusFull;
  localparam logic [StatW-1:0] StatusBadCond = pfst_pkg::StatusBadCond;
  localparam logic             RegQubitCount = pfst_pkg::RegQubitCount;

  // One input item as the driver presents it.
  typedef struct {
    logic              func;
    logic [QubitW-1:0] x;
    logic [QubitW-1:0] z;
    logic [CondW-1:0]  cid;
  } pauli_item_t;

  // One result item as the monitor expects it.
  typedef struct {
    logic [StatW-1:0] status;
    logic [CondW-1:0] cond;
    logic             empty;
    logic             last;
  } sign_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_func = FuncAdd;
  logic [QubitW-1:0] in_x_mask = '0;
  logic [QubitW-1:0] in_z_mask = '0;
  logic [CondW-1:0]  in_condition_id = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [StatW-1:0]  out_status;
  logic [CondW-1:0]  out_cond_out;
  logic              out_empty_set;
  logic              out_last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Items still to be presented, and results still to arrive.
  pauli_item_t  pauli_items[$];
  sign_result_t pending_results[$];

  // Local copy of the term table and the qubit count register.
  logic [QubitW-1:0] table_x [0:MaxTerms-1];
  logic [QubitW-1:0] table_z [0:MaxTerms-1];
  logic [CondW-1:0]  table_cond [0:MaxTerms-1];
  int                term_total = 0;
  int                qubits = 64;

  int          mismatch_count = 0;
  int          cycle_count = 0;
  logic        in_taken = 1'b0;
  logic        steady = 1'b0;
  pauli_item_t next_item;
  pauli_item_t seen_item;
  sign_result_t want;

  pauli_frame_sign_tracker_core #(
    .MAX_TERMS(MaxTerms),
    .COND_IDS (CondIds)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_x_mask      (in_x_mask),
    .in_z_mask      (in_z_mask),
    .in_condition_id(in_condition_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_cond_out   (out_cond_out),
    .out_empty_set  (out_empty_set),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a run that hangs ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Appends one expected result to the back of the list.
  function automatic void note_result(sign_result_t r);
    pending_results = {pending_results, r};
  endfunction

  // Works out the results of one accepted item and updates the local table.
  // An add stores the masked term only when its status is ok; a bad condition
  // id wins over a full table. A query folds the odd-parity terms into a set
  // of condition ids and lists them from the lowest up.
  function automatic void track_item(pauli_item_t it);
    logic [QubitW-1:0] keep;
    logic [QubitW-1:0] qx;
    logic [QubitW-1:0] qz;
    logic [63:0]       sign_set;
    sign_result_t      r;
    keep = (qubits >= 64) ? '1 : ((64'd1 << qubits) - 64'd1);
    qx = it.x & keep;
    qz = it.z & keep;
    r.status = StatusOk;
    r.cond   = '0;
    r.empty  = 1'b0;
    r.last   = 1'b1;
    if (it.func == FuncAdd) begin
      if (it.cid == 0 || it.cid > CondIds) begin
        r.status = StatusBadCond;
      end else if (term_total >= MaxTerms) begin
        r.status = StatusFull;
      end else begin
        table_x[term_total]    = qx;
        table_z[term_total]    = qz;
        table_cond[term_total] = it.cid;
        term_total++;
      end
      note_result(r);
    end else begin
      sign_set = '0;
      for (int i = 0; i < term_total; i++) begin
        if ((^(qx & table_z[i])) ^ (^(qz & table_x[i])))
          sign_set[table_cond[i] - 1] = ~sign_set[table_cond[i] - 1];
      end
      if (sign_set == 0) begin
        r.empty = 1'b1;
        note_result(r);
      end else begin
        for (int i = 0; i < 64; i++) begin
          if (sign_set[i]) begin
            r.cond = CondW'(i + 1);
            r.last = ((sign_set >> (i + 1)) == 0);
            note_result(r);
          end
        end
      end
    end
  endfunction

  function automatic void check_field(string name, int exp_val, int got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      mismatch_count++;
    end
  endfunction

  // Acceptance and result checking, both at the rising edge. The acceptance
  // flag tells the driver at the next falling edge that it may move on.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: status %0d cond %0d empty %0d last %0d",
               out_status, out_cond_out, out_empty_set, out_last);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_status);
        check_field("cond_out", want.cond, out_cond_out);
        check_field("empty_set", want.empty, out_empty_set);
        check_field("last", want.last, out_last);
      end
    end
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) begin
      seen_item.func = in_func;
      seen_item.x    = in_x_mask;
      seen_item.z    = in_z_mask;
      seen_item.cid  = in_condition_id;
      track_item(seen_item);
    end
  end

  // Driver: once the current item has gone (or none is up), present the next
  // one or leave valid low. Valid is written once per falling edge, so an
  // item that follows directly keeps valid high without a glitch.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pauli_items.size() != 0 && (steady || $urandom_range(0, 99) >= 16)) begin
        next_item = pauli_items.pop_front();
        in_func         <= next_item.func;
        in_x_mask       <= next_item.x;
        in_z_mask       <= next_item.z;
        in_condition_id <= next_item.cid;
        in_valid        <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, dropped during the steady stretch.
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 16);
  end

  task automatic queue_item(logic func, logic [QubitW-1:0] x, logic [QubitW-1:0] z,
                            logic [CondW-1:0] cid);
    pauli_item_t it;
    it.func = func;
    it.x    = x;
    it.z    = z;
    it.cid  = cid;
    pauli_items = {pauli_items, it};
  endtask

  // Random masks: dense random bits, one to three scattered bits, or the extremes.
  function automatic logic [QubitW-1:0] rand_mask();
    logic [QubitW-1:0] v;
    int style;
    style = $urandom_range(0, 9);
    v = '0;
    if (style < 5) begin
      v = {$urandom, $urandom};
    end else if (style < 8) begin
      repeat ($urandom_range(1, 3)) v[$urandom_range(0, 63)] = 1'b1;
    end else if (style == 9) begin
      v = '1;
    end
    return v;
  endfunction

  // Condition ids: mostly valid, often from a small group so that terms share
  // ids and cancel; now and then zero or above the valid range.
  function automatic logic [CondW-1:0] rand_cid();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) return '0;
    if (pick < 12) return CondW'($urandom_range(65, 127));
    if (pick < 40) return CondW'($urandom_range(1, 4));
    return CondW'($urandom_range(1, 64));
  endfunction

  task automatic queue_random_item();
    if ($urandom_range(0, 99) < 45)
      queue_item(FuncQuery, rand_mask(), rand_mask(), CondW'($urandom));
    else
      queue_item(FuncAdd, rand_mask(), rand_mask(), rand_cid());
  endtask

  // Holds the sender back until every item has gone and every result has
  // come, then lets the block settle.
  task automatic drain();
    while (pauli_items.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands at the edge with pready.
  task automatic write_qubit_count(int value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {RegQubitCount, 2'b00};
    pwdata  = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    qubits = value;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  localparam logic [QubitW-1:0] AllOnes = '1;
  localparam logic [QubitW-1:0] TopBit  = 64'h8000_0000_0000_0000;

  int qc_plan[8] = '{64, 1, 100, 17, 63, 127, 0, 40};
  int need;

  initial begin
    // Reset is held low first; the model starts from the same state.
    term_total = 0;
    qubits     = 64;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part with the reset qubit count of 64. A query on the empty
    // table comes first, then bad ids, single terms and a duplicate that
    // cancels its twin.
    queue_item(FuncQuery, '0, '0, '0);
    queue_item(FuncAdd, AllOnes, AllOnes, 7'd0);
    queue_item(FuncAdd, AllOnes, AllOnes, 7'd65);
    queue_item(FuncAdd, '0, '0, 7'd127);
    queue_item(FuncAdd, AllOnes, '0, 7'd1);
    queue_item(FuncAdd, '0, AllOnes, 7'd64);
    queue_item(FuncQuery, 64'd1, '0, '0);
    queue_item(FuncQuery, '0, TopBit, '0);
    queue_item(FuncQuery, 64'd1, 64'd1, 7'd127);
    queue_item(FuncQuery, AllOnes, AllOnes, '0);
    queue_item(FuncAdd, '0, AllOnes, 7'd64);
    queue_item(FuncQuery, 64'd1, '0, '0);
    queue_item(FuncAdd, TopBit, 64'd1, 7'd2);
    queue_item(FuncQuery, 64'd1, TopBit, '0);
    drain();

    // A qubit count of zero masks every bit, so the new term is blank.
    write_qubit_count(0);
    queue_item(FuncAdd, AllOnes, AllOnes, 7'd3);
    queue_item(FuncQuery, AllOnes, AllOnes, '0);
    queue_item(FuncQuery, 64'd1, '0, '0);
    drain();

    // One qubit in use.
    write_qubit_count(1);
    queue_item(FuncAdd, AllOnes, AllOnes, 7'd4);
    queue_item(FuncQuery, 64'd1, '0, '0);
    queue_item(FuncQuery, 64'd2, 64'd2, '0);
    drain();

    // A count above 64 behaves as 64.
    write_qubit_count(127);
    queue_item(FuncQuery, TopBit, '0, '0);
    queue_item(FuncQuery, AllOnes, '0, '0);

    // Random part: several register settings, the extremes among them. The
    // second setting runs with no idling on either side.
    qc_plan[7] = $urandom_range(2, 62);
    for (int p = 0; p < 8; p++) begin
      drain();
      write_qubit_count(qc_plan[p]);
      steady = (p == 1);
      repeat (12) queue_random_item();
    end
    drain();
    steady = 1'b0;

    // Fill the table to the top, then try adds on a full table, with bad
    // ids among them to check that they win over the full status.
    write_qubit_count(64);
    need = MaxTerms - term_total;
    repeat (need) queue_item(FuncAdd, rand_mask(), rand_mask(), CondW'($urandom_range(1, 64)));
    queue_item(FuncAdd, rand_mask(), rand_mask(), 7'd9);
    queue_item(FuncAdd, rand_mask(), rand_mask(), 7'd0);
    queue_item(FuncAdd, rand_mask(), rand_mask(), 7'd64);
    queue_item(FuncAdd, rand_mask(), rand_mask(), 7'd100);
    repeat (6) queue_item(FuncQuery, rand_mask(), rand_mask(), '0);
    drain();

    // Queries over the full table with a narrow qubit range.
    write_qubit_count(5);
    repeat (4) queue_item(FuncQuery, rand_mask(), rand_mask(), '0);
    drain();
    repeat (50) @(posedge clk);

    if (mismatch_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
